// File: hw/rtl/bounded_list_insert_delete_unit_assert.svh
// Assertion macros for the bounded list unit checkers.
`ifndef BOUNDED_LIST_INSERT_DELETE_UNIT_ASSERT_SVH
`define BOUNDED_LIST_INSERT_DELETE_UNIT_ASSERT_SVH

// Clocked assertion, disabled while reset is asserted.
`define BLID_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define BLID_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/blid_pkg.sv
// Package: types, codes and sizes shared by the bounded list unit.
`timescale 1ns / 1ps
`default_nettype none
package blid_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int VAL_W    = 32;
  localparam int POS_W    = 5;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [1:0] {
    KIND_INS_FRONT = 2'd0,
    KIND_DEL_FRONT = 2'd1,
    KIND_DEL_POS   = 2'd2,
    KIND_DEL_END   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_BOUND     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]              kind;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;
  } in_item_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [VAL_W-1:0] removed_value;
    logic [POS_W-1:0]        entry_count;
  } out_item_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    logic             insert;
    logic             remove;
    logic [IDX_W-1:0] del_idx;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// File: hw/rtl/blid_cell.sv
// One storage cell of the list chain: shifts right on insert, left on delete.
`timescale 1ns / 1ps
`default_nettype none
module blid_cell
  import blid_pkg::*;
(
  input  wire logic              clk,
  input  wire logic [IDX_W-1:0]  cell_idx,
  input  wire cell_ctrl_t        ctrl,
  input  wire logic [VAL_W-1:0]  left_data,
  input  wire logic [VAL_W-1:0]  right_data,
  output logic      [VAL_W-1:0]  data_out,
  output logic      [VAL_W-1:0]  rm_data
);

  logic [VAL_W-1:0] data_r;
  logic [VAL_W-1:0] data_nxt;
  logic             hit;
  logic             at_or_after;

  assign hit         = (cell_idx == ctrl.del_idx);
  assign at_or_after = (cell_idx >= ctrl.del_idx);

  always_comb begin
    data_nxt = data_r;
    if (ctrl.insert) begin
      data_nxt = left_data;
    end else if (ctrl.remove && at_or_after) begin
      data_nxt = right_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_out = data_r;
  assign rm_data  = (ctrl.remove && hit) ? data_r : '0;

endmodule
`default_nettype wire

// File: hw/rtl/bounded_list_insert_delete_unit.sv
// Top level: bounded ordered list built from a chain of shifting cells.
//
//   channel | ports                         | payload
//   --------+-------------------------------+------------
//   input   | in_valid / in_ready / in_item | in_item_t
//   result  | out_valid/ out_ready/ out_item| out_item_t
//
// One transaction per cycle unless the result stalls: the affected cells shift
// and the result is registered at the same clock edge.
// The result register frees in_ready whenever it is empty or being taken.
// Synchronous active-low reset empties the list; cell contents are not reset.
// A stalled result holds in_ready low until it is taken.
`timescale 1ns / 1ps
`default_nettype none
module bounded_list_insert_delete_unit
  import blid_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_item
);

  logic             accept;
  logic [CNT_W-1:0] occ_r;
  logic [CNT_W-1:0] occ_nxt;
  logic             out_valid_r;
  out_item_t        out_item_r;
  status_t          status;
  logic             do_ins;
  logic             do_del;
  logic [IDX_W-1:0] del_idx;
  logic [POS_W-1:0] pos_m1;
  logic [CNT_W-1:0] occ_m1;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] occ_ext;
  cell_ctrl_t       ctrl;
  logic [VAL_W-1:0] removed;

  logic [VAL_W-1:0] cell_data [CAPACITY];
  logic [VAL_W-1:0] cell_rm   [CAPACITY];
  logic [VAL_W-1:0] nbr_left  [CAPACITY];
  logic [VAL_W-1:0] nbr_right [CAPACITY];

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign pos_m1  = in_item.position - POS_W'(1);
  assign occ_m1  = occ_r - CNT_W'(1);
  assign pos_ext = CMP_W'(in_item.position);
  assign occ_ext = CMP_W'(occ_r);

  always_comb begin
    status  = ST_DONE;
    do_ins  = 1'b0;
    do_del  = 1'b0;
    del_idx = '0;
    if (in_item.kind == KIND_INS_FRONT) begin
      if (occ_r == CNT_W'(CAPACITY)) begin
        status = ST_FULL;
      end else begin
        do_ins = 1'b1;
      end
    end else if (occ_r == '0) begin
      status = ST_UNDERFLOW;
    end else begin
      unique case (kind_t'(in_item.kind))
        KIND_DEL_FRONT: begin
          do_del  = 1'b1;
          del_idx = '0;
        end
        KIND_DEL_POS: begin
          if (pos_ext == '0 || pos_ext > occ_ext) begin
            status = ST_BOUND;
          end else begin
            do_del  = 1'b1;
            del_idx = IDX_W'(pos_m1);
          end
        end
        KIND_DEL_END: begin
          do_del  = 1'b1;
          del_idx = IDX_W'(occ_m1);
        end
        default: begin
          do_del  = 1'b0;
        end
      endcase
    end
  end

  assign ctrl.insert  = accept && do_ins;
  assign ctrl.remove  = accept && do_del;
  assign ctrl.del_idx = del_idx;

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      if (gi == 0) begin : g_head
        assign nbr_left[gi] = in_item.value;
      end else begin : g_mid_l
        assign nbr_left[gi] = cell_data[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_tail
        assign nbr_right[gi] = cell_data[gi];
      end else begin : g_mid_r
        assign nbr_right[gi] = cell_data[gi+1];
      end
      blid_cell u_cell (
        .clk        (clk),
        .cell_idx   (IDX_W'(gi)),
        .ctrl       (ctrl),
        .left_data  (nbr_left[gi]),
        .right_data (nbr_right[gi]),
        .data_out   (cell_data[gi]),
        .rm_data    (cell_rm[gi])
      );
    end
  endgenerate

  always_comb begin
    removed = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      removed = removed | cell_rm[i];
    end
  end

  always_comb begin
    occ_nxt = occ_r;
    if (ctrl.insert) begin
      occ_nxt = occ_r + CNT_W'(1);
    end else if (ctrl.remove) begin
      occ_nxt = occ_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_item_r.status        <= status;
      out_item_r.removed_value <= removed;
      out_item_r.entry_count   <= POS_W'(occ_nxt);
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
`default_nettype wire

// File: hw/rtl/blid_checker.sv
// Port-level checker for the bounded list unit, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "bounded_list_insert_delete_unit_assert.svh"
module blid_checker
  import blid_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_item
);

  `BLID_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_item), "stalled result changed")
  `BLID_ASSERT(a_accept_result, clk, rst_n, in_valid && in_ready |=> out_valid, "accepted transaction produced no result")
  `BLID_ASSERT(a_underflow_empty, clk, rst_n, out_valid && out_item.status == ST_UNDERFLOW |-> out_item.removed_value == '0 && out_item.entry_count == '0, "underflow with nonempty list")
  `BLID_ASSERT(a_full_count, clk, rst_n, out_valid && out_item.status == ST_FULL |-> out_item.entry_count == POS_W'(CAPACITY), "full flagged below capacity")
  `BLID_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_valid, "result valid right after reset")

endmodule

bind bounded_list_insert_delete_unit blid_checker u_blid_checker (.*);
`default_nettype wire
